// ===== hdl/idar_pkg.sv =====
// ----------------------------------------------------------------------------
// idar_pkg
// Shared widths, action and status codes, and controller-to-datapath
// commands for the identifier allocator.
// ----------------------------------------------------------------------------
package idar_pkg;

    // Field and storage widths.
    localparam int ID_W       = 8;
    localparam int OBJ_W      = 6;
    localparam int CNT_W      = 9;
    localparam int ACT_W      = 3;
    localparam int STAT_W     = 2;
    localparam int ID_SPACE   = 256;
    localparam int OBJ_SLOTS  = 64;

    // The bitmap search splits the id space into groups of bits.
    localparam int BIT_W      = 4;
    localparam int GRP_SIZE   = 1 << BIT_W;
    localparam int GRP_IDX_W  = ID_W - BIT_W;
    localparam int GRP_N      = ID_SPACE / GRP_SIZE;

    // Action codes carried by an input transaction.
    localparam logic [ACT_W-1:0] ACT_REQUEST    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REGISTER   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_UNREGISTER = 3'd2;
    localparam logic [ACT_W-1:0] ACT_BIND       = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DESTROY    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_QUERY      = 3'd5;

    // Status codes returned with each result transaction.
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STAT_W-1:0] ST_BOUND     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NO_EFFECT = 2'd3;

    // Step commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic scan;
        logic group;
        logic pick;
        logic exec;
    } cmd_t;

    // Index of the lowest set bit of a group; zero when none is set.
    function automatic logic [BIT_W-1:0] lowest_set(input logic [GRP_SIZE-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = GRP_SIZE - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== hdl/idar_ctrl.sv =====
// ----------------------------------------------------------------------------
// idar_ctrl
// Sequencer for the allocator: accepts a transaction, steps the datapath
// through scan, group select, bit pick and update, and owns the output valid.
// ----------------------------------------------------------------------------
module idar_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output idar_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_GROUP,
        S_PICK,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    // The output slot can take a new result when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next-state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = S_GROUP;
            end
            S_GROUP:
            begin
                cmd.group  = 1'b1;
                state_next = S_PICK;
            end
            S_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/idar_dp.sv =====
// ----------------------------------------------------------------------------
// idar_dp
// Datapath: used and freed bitmaps, rising counter, object binding table,
// two-level lowest-bit search and the result register.
// ----------------------------------------------------------------------------
module idar_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  idar_pkg::cmd_t                  cmd,
    input  logic [idar_pkg::ACT_W-1:0]      action,
    input  logic [idar_pkg::ID_W-1:0]       id,
    input  logic [idar_pkg::OBJ_W-1:0]      object,
    input  logic                            object_present,
    output logic [idar_pkg::ID_W-1:0]       result_id,
    output logic [idar_pkg::STAT_W-1:0]     status,
    output logic                            id_in_use,
    output logic [idar_pkg::CNT_W-1:0]      used_count
);

    localparam int ID_W      = idar_pkg::ID_W;
    localparam int OBJ_W     = idar_pkg::OBJ_W;
    localparam int CNT_W     = idar_pkg::CNT_W;
    localparam int ID_SPACE  = idar_pkg::ID_SPACE;
    localparam int OBJ_SLOTS = idar_pkg::OBJ_SLOTS;
    localparam int BIT_W     = idar_pkg::BIT_W;
    localparam int GRP_SIZE  = idar_pkg::GRP_SIZE;
    localparam int GRP_IDX_W = idar_pkg::GRP_IDX_W;
    localparam int GRP_N     = idar_pkg::GRP_N;

    // Captured transaction.
    logic [idar_pkg::ACT_W-1:0] action_reg;
    logic [ID_W-1:0]            id_reg;
    logic [OBJ_W-1:0]           obj_reg;
    logic                       has_obj_reg;

    // Allocation state.
    logic [ID_SPACE-1:0]  used_reg, used_next;
    logic [ID_SPACE-1:0]  freed_reg, freed_next;
    logic [ID_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic [OBJ_SLOTS-1:0] bvld_reg, bvld_next;

    // Binding id memory and its registered read data.
    logic [ID_W-1:0] bind_mem [OBJ_SLOTS];
    logic [ID_W-1:0] bid_reg;

    // Search pipeline registers.
    logic [GRP_N-1:0]     freed_grp_reg;
    logic [GRP_N-1:0]     cand_grp_reg;
    logic                 sel_freed_reg;
    logic                 found_reg;
    logic [GRP_IDX_W-1:0] grp_reg;
    logic [ID_W-1:0]      grant_reg;

    // Result registers.
    logic [ID_W-1:0]            res_reg;
    logic [idar_pkg::STAT_W-1:0] stat_reg;
    logic                       inuse_reg;

    // Combinational search signals.
    logic [ID_SPACE-1:0]  cand;
    logic [GRP_N-1:0]     freed_grp;
    logic [GRP_N-1:0]     cand_grp;
    logic [GRP_N-1:0]     grp_flags;
    logic [GRP_SIZE-1:0]  slice;
    logic [ID_W-1:0]      slice_base;

    // Update decode signals.
    logic                       fa_en, ub_en;
    logic [ID_W-1:0]            fa_addr, ub_addr;
    logic                       bind_we, bv_set, bv_clr;
    logic [ID_W-1:0]            bind_wdata;
    logic [ID_W-1:0]            res_c;
    logic [idar_pkg::STAT_W-1:0] stat_c;
    logic                       inuse_c;
    logic                       bvalid;

    // Counter candidates: unused ids above the counter.
    always_comb
    begin
        for (int k = 0; k < ID_SPACE; k++)
        begin
            cand[k] = !used_reg[k] && (ID_W'(k) > cnt_reg);
        end
    end

    // Per-group summary flags for the first search level.
    always_comb
    begin
        for (int g = 0; g < GRP_N; g++)
        begin
            freed_grp[g] = |freed_reg[g*GRP_SIZE +: GRP_SIZE];
            cand_grp[g]  = |cand[g*GRP_SIZE +: GRP_SIZE];
        end
    end

    // Group choice: freed ids win over counter candidates.
    assign grp_flags  = (|freed_grp_reg) ? freed_grp_reg : cand_grp_reg;
    assign slice_base = {grp_reg, BIT_W'(0)};
    assign slice      = sel_freed_reg ? freed_reg[slice_base +: GRP_SIZE]
                                      : cand[slice_base +: GRP_SIZE];

    // Lowest set group index over the group flags.
    function automatic logic [GRP_IDX_W-1:0] lowest_grp(input logic [GRP_N-1:0] v);
        logic [GRP_IDX_W-1:0] idx;
        idx = '0;
        for (int i = GRP_N - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = GRP_IDX_W'(i);
            end
        end
        return idx;
    endfunction

    assign bvalid = bvld_reg[obj_reg];

    // Action decode at the update step.
    always_comb
    begin
        fa_en      = 1'b0;
        fa_addr    = '0;
        ub_en      = 1'b0;
        ub_addr    = '0;
        bind_we    = 1'b0;
        bind_wdata = '0;
        bv_set     = 1'b0;
        bv_clr     = 1'b0;
        cnt_next   = cnt_reg;
        res_c      = '0;
        stat_c     = idar_pkg::ST_OK;
        inuse_c    = 1'b0;
        case (action_reg)
            idar_pkg::ACT_REQUEST:
            begin
                if (has_obj_reg && bvalid)
                begin
                    res_c  = bid_reg;
                    stat_c = idar_pkg::ST_BOUND;
                end
                else if (found_reg)
                begin
                    ub_en   = 1'b1;
                    ub_addr = grant_reg;
                    if (!sel_freed_reg)
                    begin
                        cnt_next = grant_reg;
                    end
                    if (has_obj_reg)
                    begin
                        bind_we    = 1'b1;
                        bind_wdata = grant_reg;
                        bv_set     = 1'b1;
                    end
                    res_c = grant_reg;
                end
                else
                begin
                    stat_c = idar_pkg::ST_EXHAUSTED;
                end
            end
            idar_pkg::ACT_REGISTER:
            begin
                if (used_reg[id_reg] && !freed_reg[id_reg])
                begin
                    stat_c = idar_pkg::ST_NO_EFFECT;
                end
                else
                begin
                    ub_en   = 1'b1;
                    ub_addr = id_reg;
                end
            end
            idar_pkg::ACT_UNREGISTER:
            begin
                if (freed_reg[id_reg] && !used_reg[id_reg])
                begin
                    stat_c = idar_pkg::ST_NO_EFFECT;
                end
                else
                begin
                    fa_en   = 1'b1;
                    fa_addr = id_reg;
                end
            end
            idar_pkg::ACT_BIND:
            begin
                // Release the earlier id of the object, then take the new one.
                fa_en      = bvalid;
                fa_addr    = bid_reg;
                ub_en      = 1'b1;
                ub_addr    = id_reg;
                bind_we    = 1'b1;
                bind_wdata = id_reg;
                bv_set     = 1'b1;
            end
            idar_pkg::ACT_DESTROY:
            begin
                if (!bvalid)
                begin
                    stat_c = idar_pkg::ST_NO_EFFECT;
                end
                else
                begin
                    bv_clr  = 1'b1;
                    fa_en   = 1'b1;
                    fa_addr = bid_reg;
                end
            end
            idar_pkg::ACT_QUERY:
            begin
                inuse_c = used_reg[id_reg];
            end
            default:
            begin
                stat_c = idar_pkg::ST_NO_EFFECT;
            end
        endcase
    end

    // Bitmap and count update: a release first, then a take.
    always_comb
    begin
        used_next  = used_reg;
        freed_next = freed_reg;
        total_next = total_reg;
        bvld_next  = bvld_reg;
        if (fa_en)
        begin
            freed_next[fa_addr] = 1'b1;
            if (used_next[fa_addr])
            begin
                used_next[fa_addr] = 1'b0;
                total_next         = total_next - CNT_W'(1);
            end
        end
        if (ub_en)
        begin
            freed_next[ub_addr] = 1'b0;
            if (!used_next[ub_addr])
            begin
                used_next[ub_addr] = 1'b1;
                total_next         = total_next + CNT_W'(1);
            end
        end
        if (bv_set)
        begin
            bvld_next[obj_reg] = 1'b1;
        end
        if (bv_clr)
        begin
            bvld_next[obj_reg] = 1'b0;
        end
    end

    // Control state: bitmaps, counter, count and binding valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            freed_reg <= '0;
            cnt_reg   <= '0;
            total_reg <= '0;
            bvld_reg  <= '0;
        end
        else if (cmd.exec)
        begin
            used_reg  <= used_next;
            freed_reg <= freed_next;
            cnt_reg   <= cnt_next;
            total_reg <= total_next;
            bvld_reg  <= bvld_next;
        end
    end

    // Binding memory: read during the scan step, written at the update.
    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            bid_reg <= bind_mem[obj_reg];
        end
        if (cmd.exec && bind_we)
        begin
            bind_mem[obj_reg] <= bind_wdata;
        end
    end

    // Transaction capture, search pipeline and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg  <= action;
            id_reg      <= id;
            obj_reg     <= object;
            has_obj_reg <= object_present;
        end
        if (cmd.scan)
        begin
            freed_grp_reg <= freed_grp;
            cand_grp_reg  <= cand_grp;
        end
        if (cmd.group)
        begin
            sel_freed_reg <= |freed_grp_reg;
            found_reg     <= |grp_flags;
            grp_reg       <= lowest_grp(grp_flags);
        end
        if (cmd.pick)
        begin
            grant_reg <= {grp_reg, idar_pkg::lowest_set(slice)};
        end
        if (cmd.exec)
        begin
            res_reg   <= res_c;
            stat_reg  <= stat_c;
            inuse_reg <= inuse_c;
        end
    end

    // The used count is reported after the update, straight from the count register.
    assign result_id  = res_reg;
    assign status     = stat_reg;
    assign id_in_use  = inuse_reg;
    assign used_count = total_reg;

endmodule

// ===== hdl/id_allocator_with_reuse.sv =====
// A result is registered after the scan, group select, bit pick and update
// steps of the bitmap search sequencer; the update waits while the output slot
// is full, and a new transaction is accepted only once the update is done.
// Reset clears the used and freed bitmaps, the counter, the used count and
// the binding valid bits at once; the block is ready straight out of reset.
// ----------------------------------------------------------------------------
// id_allocator_with_reuse
// Identifier allocator with lowest-freed reuse, a rising counter and an
// object-to-id binding table.
// ----------------------------------------------------------------------------
module id_allocator_with_reuse (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [idar_pkg::ACT_W-1:0]       action,
    input  logic [idar_pkg::ID_W-1:0]        id,
    input  logic [idar_pkg::OBJ_W-1:0]       object,
    input  logic                             object_present,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [idar_pkg::ID_W-1:0]        result_id,
    output logic [idar_pkg::STAT_W-1:0]      status,
    output logic                             id_in_use,
    output logic [idar_pkg::CNT_W-1:0]       used_count
);

    idar_pkg::cmd_t cmd;

    // Sequencer.
    idar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Maps, binding table and search.
    idar_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .action         (action),
        .id             (id),
        .object         (object),
        .object_present (object_present),
        .result_id      (result_id),
        .status         (status),
        .id_in_use      (id_in_use),
        .used_count     (used_count)
    );

endmodule
